@@ rtl/sha0f_pkg.sv @@
// ----------------------------------------------------------------------------
// sha0f_pkg: shared types and constants for the folded SHA-0 hash
// Round constants, initial chaining value, queue item and result bundle
// types, and the per-round mixing functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha0f_pkg;

    // Round constants, also used as fold masks
    localparam logic [31:0] RK1 = 32'h5a827999;
    localparam logic [31:0] RK2 = 32'h6ed9eba1;
    localparam logic [31:0] RK3 = 32'h8f1bbcdc;
    localparam logic [31:0] RK4 = 32'hca62c1d6;

    // Initial chaining value, word 0 at index 0
    localparam logic [4:0][31:0] CHAIN_IV = {
        32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LAST_BYTE  = 6'd63;
    localparam logic [5:0] LEN_START  = 6'd60;

    // Input transaction as held in the front queue
    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } item_t;

    typedef logic [3:0][31:0] digest_t;

    // Digest hand-off from the engine to the result buffer
    typedef struct packed {
        logic    load;
        digest_t words;
    } res_load_t;

    // Round constant by round number
    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20)      k = RK1;
        else if (r < 7'd40) k = RK2;
        else if (r < 7'd60) k = RK3;
        else                k = RK4;
        return k;
    endfunction

    // Round boolean function by round number
    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20)      f = (b & c) | (~b & d);
        else if (r < 7'd40) f = b ^ c ^ d;
        else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
        else                f = b ^ c ^ d;
        return f;
    endfunction

    // Fold mask for digest word j
    function automatic logic [31:0] fold_mask(input logic [1:0] j);
        logic [31:0] m;
        case (j)
            2'd0:    m = RK1;
            2'd1:    m = RK2;
            2'd2:    m = RK3;
            default: m = RK4;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sha0f_front.sv @@
// ----------------------------------------------------------------------------
// sha0f_front: input queue
// Accepts byte and finish transactions and holds them in a small FIFO until
// the hash engine takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha0f_front #(
    parameter int DEPTH = 4
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  wire sha0f_pkg::item_t push_item,
    output logic                 full,
    output logic                 q_valid,
    output sha0f_pkg::item_t     q_item,
    input  wire                  q_pop
);
    import sha0f_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_pop && q_valid;

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sha0f_core.sv @@
// ----------------------------------------------------------------------------
// sha0f_core: SHA-0 compression engine
// Packs bytes into a 16-word schedule window, runs 80 rounds per block,
// generates padding and length bytes on finish, and folds the digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha0f_core (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   q_valid,
    input  wire sha0f_pkg::item_t q_item,
    output logic                  q_pop,
    input  wire                   out_ready,
    output sha0f_pkg::res_load_t  res
);
    import sha0f_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PAD    = 5'b00010,
        ST_ROUND  = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FOLD   = 5'b10000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [4:0][31:0]  chain_reg;
    logic [4:0][31:0]  work_reg;     // a..e
    logic [15:0][31:0] w_reg;        // schedule window, w_reg[0] is current
    logic [23:0]       acc_reg;      // partial word
    logic [31:0]       total_reg;
    logic [5:0]        fill_reg;
    logic [6:0]        round_reg;
    logic              pad_reg;      // finish in progress
    logic              marker_reg;   // 0x80 already placed
    logic              len_ok_reg;   // current block carries the length

    logic              wr_en;
    logic              msg_byte;
    logic              start_pad;
    logic [7:0]        wr_byte;
    logic [7:0]        pad_byte;
    logic [7:0]        len_byte;
    logic              block_done;
    logic [31:0]       t_sum;
    logic [31:0]       w_new;

    // Length byte for the current position, most significant first
    always_comb
    begin
        case (fill_reg[1:0])
            2'd0:    len_byte = total_reg[31:24];
            2'd1:    len_byte = total_reg[23:16];
            2'd2:    len_byte = total_reg[15:8];
            default: len_byte = total_reg[7:0];
        endcase
    end

    // Padding byte source
    always_comb
    begin
        if (!marker_reg)
        begin
            pad_byte = PAD_MARK;
        end
        else if (len_ok_reg && (fill_reg >= LEN_START))
        begin
            pad_byte = len_byte;
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // Byte source selection and queue pop
    always_comb
    begin
        q_pop     = 1'b0;
        wr_en     = 1'b0;
        msg_byte  = 1'b0;
        start_pad = 1'b0;
        wr_byte   = q_item.data_byte;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (!q_item.kind)
                    begin
                        wr_en    = 1'b1;
                        msg_byte = 1'b1;
                    end
                    else
                    begin
                        start_pad = 1'b1;
                    end
                end
            end
            ST_PAD:
            begin
                wr_en   = 1'b1;
                wr_byte = pad_byte;
            end
            default:
            begin
            end
        endcase
    end

    assign block_done = wr_en && (fill_reg == LAST_BYTE);

    // One SHA round and schedule expansion
    assign t_sum = {work_reg[0][26:0], work_reg[0][31:27]}
                 + round_f(round_reg, work_reg[1], work_reg[2], work_reg[3])
                 + work_reg[4] + w_reg[0] + round_k(round_reg);
    assign w_new = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];

    // Folded digest
    always_comb
    begin
        res.load = (state_reg == ST_FOLD) && out_ready;
        for (int j = 0; j < 4; j++)
        begin
            res.words[j] = chain_reg[j] + (chain_reg[4] & fold_mask(2'(j)));
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (block_done)     state_next = ST_ROUND;
                else if (start_pad) state_next = ST_PAD;
            end
            ST_PAD:
            begin
                if (block_done) state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (round_reg == LAST_ROUND) state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (!pad_reg)        state_next = ST_IDLE;
                else if (len_ok_reg) state_next = ST_FOLD;
                else                 state_next = ST_PAD;
            end
            ST_FOLD:
            begin
                if (out_ready) state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath registers: schedule window, partial word, working variables
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            acc_reg <= {acc_reg[15:0], wr_byte};
            if (fill_reg[1:0] == 2'd3)
            begin
                w_reg <= {{acc_reg, wr_byte}, w_reg[15:1]};
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            w_reg <= {w_new, w_reg[15:1]};
        end

        if (block_done)
        begin
            work_reg <= chain_reg;
        end
        else if (state_reg == ST_ROUND)
        begin
            work_reg[0] <= t_sum;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

    // Control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            chain_reg  <= CHAIN_IV;
            total_reg  <= '0;
            fill_reg   <= '0;
            round_reg  <= '0;
            pad_reg    <= 1'b0;
            marker_reg <= 1'b0;
            len_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (msg_byte)
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (wr_en)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (state_reg == ST_PAD)
            begin
                marker_reg <= 1'b1;
            end

            // finish: marker and length fit this block unless 60+ bytes are held
            if (start_pad)
            begin
                pad_reg    <= 1'b1;
                marker_reg <= 1'b0;
                len_ok_reg <= (fill_reg < LEN_START);
            end

            if (block_done)
            begin
                round_reg <= '0;
            end
            else if (state_reg == ST_ROUND)
            begin
                round_reg <= round_reg + 1'b1;
            end

            if (state_reg == ST_UPDATE)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
                if (pad_reg)
                begin
                    len_ok_reg <= 1'b1;
                end
            end

            // digest handed off: restart the hash
            if (res.load)
            begin
                chain_reg <= CHAIN_IV;
                total_reg <= '0;
                fill_reg  <= '0;
                pad_reg   <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sha0f_out.sv @@
// ----------------------------------------------------------------------------
// sha0f_out: digest result buffer
// Holds one folded 128-bit digest and presents it as four word transactions
// in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha0f_out (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire sha0f_pkg::res_load_t res,
    output logic                      ready,
    output logic                      empty,
    input  wire                       pop,
    output logic [31:0]               digest_word,
    output logic [1:0]                word_index,
    output logic                      last_word
);
    import sha0f_pkg::*;

    digest_t    words_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       do_pop;

    assign ready       = !valid_reg;
    assign empty       = !valid_reg;
    assign do_pop      = pop && valid_reg;
    assign digest_word = words_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 2'd3);

    // Digest words
    always_ff @(posedge clk)
    begin
        if (res.load && !valid_reg)
        begin
            words_reg <= res.words;
        end
    end

    // Word sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            if (res.load && !valid_reg)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= '0;
            end
            else if (do_pop)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (last_word)
                begin
                    valid_reg <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sha0_folded_128_hash.sv @@
// Flow: an accepted byte is registered in the input queue and absorbed when the
// engine is idle; a full block then runs 80 rounds and the chaining update.
// Finish: padding fills the block (two blocks if 60 or more bytes are held),
// each runs its rounds and update, then the fold hands the digest on as four
// word pops. The queue takes items while the engine runs, until it is full.
// Reset: chaining value to the SHA initial values, counts cleared, queues empty.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// sha0_folded_128_hash: folded 128-bit SHA-0 over a byte stream
// Input queue feeding a one-round-per-cycle compression engine and a
// four-word digest result buffer.
// ----------------------------------------------------------------------------
module sha0_folded_128_hash #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         push,
    output logic        full,
    input  wire         kind,
    input  wire  [7:0]  data_byte,
    output logic        empty,
    input  wire         pop,
    output logic [31:0] digest_word,
    output logic [1:0]  word_index,
    output logic        last_word
);
    import sha0f_pkg::*;

    item_t     push_item;
    item_t     q_item;
    logic      q_valid;
    logic      q_pop;
    logic      out_ready;
    res_load_t res;

    assign push_item.kind      = kind;
    assign push_item.data_byte = data_byte;

    // Input transaction queue
    sha0f_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Compression engine
    sha0f_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_ready (out_ready),
        .res       (res)
    );

    // Digest result buffer
    sha0f_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .ready       (out_ready),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

`default_nettype wire

@@ tb/sv/sha0_folded_128_hash_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha0_folded_128_hash_tb: self-checking regression for the folded SHA-0 hash
// Streams byte messages and finish transactions into the input queue, keeps
// its own SHA-0 model of chaining value, block buffer and byte count, and
// checks every digest word popped from the result queue field by field.
// ----------------------------------------------------------------------------
module sha0_folded_128_hash_tb;

    import sha0f_pkg::*;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   DRAIN_WAIT  = 400;
    localparam int   STALL_RATE  = 23;
    localparam int   HOLD_LEN    = 600;

    typedef struct {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        last;
    } digest_beat_t;

    // DUT ports
    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        kind;
    logic [7:0]  data_byte;
    logic        empty;
    logic        pop;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    // Hash model state
    logic [31:0] chain[5];
    logic [31:0] byte_count;
    logic [7:0]  blk[64];
    int unsigned fill;

    digest_beat_t expected_digest[$];

    int  errors;
    int  items_sent;
    int  messages_done;
    int  words_checked;
    int  cycle_count;
    int  hold_left;
    bit  quiet;

    sha0_folded_128_hash u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .data_byte   (data_byte),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    // Clock, 4 ns period
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Model: restart the chaining value and counts
    function automatic void hash_restart();
        for (int i = 0; i < 5; i++)
        begin
            chain[i] = CHAIN_IV[i];
        end
        byte_count = '0;
        fill = 0;
    endfunction

    // Model: 80-round SHA-0 compression of blk into chain
    function automatic void compress_blk();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int r = 0; r < 16; r++)
        begin
            w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
        end
        // no one-bit rotate in the schedule
        for (int r = 16; r < 80; r++)
        begin
            w[r] = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK1;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RK2;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK3;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK4;
            end
            t = {a[26:0], a[31:27]} + f + e + w[r] + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    // Model: absorb one accepted transaction, queue any digest words
    function automatic void hash_absorb(input logic k_in, input logic [7:0] b_in);
        int unsigned pos;
        logic [31:0] masks[4];
        digest_beat_t beat;
        if (k_in == KIND_BYTE)
        begin
            blk[fill] = b_in;
            byte_count += 1;
            fill = (fill + 1) % 64;
            if (fill == 0)
                compress_blk();
            return;
        end
        pos = fill;
        blk[pos] = PAD_MARK;
        pos++;
        // marker leaves no room for the length: extra zero block first
        if (pos > 60)
        begin
            for (int i = pos; i < 64; i++)
                blk[i] = 8'h00;
            compress_blk();
            pos = 0;
        end
        for (int i = pos; i < 60; i++)
            blk[i] = 8'h00;
        {blk[60], blk[61], blk[62], blk[63]} = byte_count;
        compress_blk();
        masks = '{RK1, RK2, RK3, RK4};
        for (int j = 0; j < 4; j++)
        begin
            beat.word = chain[j] + (chain[4] & masks[j]);
            beat.idx  = 2'(j);
            beat.last = (j == 3);
            expected_digest.push_back(beat);
        end
        hash_restart();
        messages_done++;
    endfunction

    // Sender: one transaction, random gaps unless quiet
    task automatic send_item(input logic k_in, input logic [7:0] b_in);
        if (!quiet)
        begin
            while ($urandom_range(99) < STALL_RATE)
            begin
                push <= 1'b0;
                @(negedge clk);
            end
        end
        push      <= 1'b1;
        kind      <= k_in;
        data_byte <= b_in;
        @(posedge clk);
        while (full)
            @(posedge clk);
        hash_absorb(k_in, b_in);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic sender_idle();
        push <= 1'b0;
        @(negedge clk);
    endtask

    // One message of random bytes followed by a finish
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_item(KIND_BYTE, 8'($urandom_range(255)));
        send_item(KIND_FINISH, 8'($urandom_range(255)));
    endtask

    // Receiver: random pops, plus a counted hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
            pop <= quiet || ($urandom_range(99) >= STALL_RATE);
    end

    // Result checker
    always @(posedge clk)
    begin
        digest_beat_t exp_beat;
        if (rst_n && pop && !empty)
        begin
            if (expected_digest.size() == 0)
            begin
                $error("digest result with none expected: word %h index %0d",
                       digest_word, word_index);
                errors++;
            end
            else
            begin
                exp_beat = expected_digest.pop_front();
                words_checked++;
                if (digest_word !== exp_beat.word)
                begin
                    $error("digest_word mismatch: expected %h, got %h",
                           exp_beat.word, digest_word);
                    errors++;
                end
                if (word_index !== exp_beat.idx)
                begin
                    $error("word_index mismatch: expected %0d, got %0d",
                           exp_beat.idx, word_index);
                    errors++;
                end
                if (last_word !== exp_beat.last)
                begin
                    $error("last_word mismatch: expected %0d, got %0d",
                           exp_beat.last, last_word);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d digest words outstanding",
                     cycle_count, expected_digest.size());
            $display("sha0_folded_128_hash regression: fail");
            $finish;
        end
    end

    // Two empty messages, each a padding-only block
    task automatic test_empty_message();
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_FINISH, 8'hff);
    endtask

    // Byte extremes, and finish data that must be ignored
    task automatic test_byte_extremes();
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_BYTE, 8'h80);
        send_item(KIND_BYTE, 8'h7f);
        send_item(KIND_BYTE, 8'h01);
        send_item(KIND_FINISH, 8'hff);
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_FINISH, 8'h00);
        send_item(KIND_BYTE, 8'h55);
        send_item(KIND_BYTE, 8'haa);
        send_item(KIND_FINISH, 8'h80);
    endtask

    // Marker on the last byte of a block, length in a second padded block
    task automatic test_pad_boundaries();
        send_message(63);
    endtask

    // Receiver holds off while the sender keeps pushing until full stalls it
    task automatic test_backpressure();
        sender_idle();
        @(posedge clk);
        hold_left = HOLD_LEN;
        @(negedge clk);
        for (int m = 0; m < 4; m++)
            send_message($urandom_range(3, 2));
    endtask

    // Back-to-back traffic on both sides
    task automatic test_steady_stream();
        quiet = 1'b1;
        for (int m = 0; m < 3; m++)
            send_message($urandom_range(3));
        quiet = 1'b0;
    endtask

    // Random short message lengths
    task automatic test_random_messages();
        int start_items;
        int len;
        start_items = items_sent;
        while (items_sent - start_items < 12)
        begin
            len = $urandom_range(5);
            send_message(len);
        end
    endtask

    // Sequence
    initial
    begin
        errors        = 0;
        items_sent    = 0;
        messages_done = 0;
        words_checked = 0;
        cycle_count   = 0;
        hold_left     = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        kind          = KIND_BYTE;
        data_byte     = 8'h00;
        hash_restart();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_message();
        test_byte_extremes();
        test_pad_boundaries();
        test_backpressure();
        test_steady_stream();
        test_random_messages();
        sender_idle();

        // drain
        while (expected_digest.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("covered %0d transactions, %0d messages, %0d digest words checked",
                 items_sent, messages_done, words_checked);
        $display("incl. two-block padding, ignored finish data, long result stall");
        if (errors == 0 && expected_digest.size() == 0)
            $display("sha0_folded_128_hash regression: pass");
        else
        begin
            if (expected_digest.size() != 0)
                $error("%0d digest words never arrived", expected_digest.size());
            $display("sha0_folded_128_hash regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/sha0f_pkg.sv
rtl/sha0f_front.sv
rtl/sha0f_core.sv
rtl/sha0f_out.sv
rtl/sha0_folded_128_hash.sv
tb/sv/sha0_folded_128_hash_tb.sv
